// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the upsampler RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// The condition must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- rtl/core/ups_pkg.sv -----
// Package of the 2x upsampler: sizes, register indexes, sequencer types.
// Depends on nothing.
`timescale 1ns / 1ps

package ups_pkg;

   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_HEIGHT_DEF = 2048;
   localparam int PIXEL_BITS_DEF = 16;

   localparam int COORD_BITS     = 12;
   localparam int PLANE_BITS     = 16;
   localparam int GEOM_BITS      = 12;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODE        = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IN_WIDTH    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IN_HEIGHT   = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PLANE_COUNT = 2'd3;

   localparam logic MODE_BILINEAR = 1'b0;
   localparam logic MODE_NEAREST  = 1'b1;

   typedef enum logic [2:0] {
      ROW_TOP,
      ROW_UP,
      ROW_DOWN,
      ROW_BOTTOM,
      ROW_NEAR_EVEN,
      ROW_NEAR_ODD
   } row_kind_type;

   typedef enum logic [2:0] {
      COL_FIRST,
      COL_ODD,
      COL_EVEN,
      COL_EDGE,
      COL_NEAR_EVEN,
      COL_NEAR_ODD
   } col_kind_type;

   typedef struct packed {
      logic                  near;
      logic                  first_col;
      logic                  last_col;
      logic                  first_row;
      logic                  last_row;
      logic [COORD_BITS-1:0] row2;
      logic [COORD_BITS-1:0] col2;
      logic [COORD_BITS-1:0] bottom_row;
      logic [COORD_BITS-1:0] edge_col;
      logic [PLANE_BITS-1:0] plane;
   } ups_item_type;

endpackage

// ----- rtl/core/ups_if.sv -----
// Request and response channel interfaces of the 2x upsampler.
// Depends on ups_pkg.
`timescale 1ns / 1ps

interface ups_req_if #(
   parameter int PIXEL_BITS = ups_pkg::PIXEL_BITS_DEF
);
   import ups_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [PIXEL_BITS-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink (input valid, input pixel, output ready);
endinterface

interface ups_rsp_if #(
   parameter int PIXEL_BITS = ups_pkg::PIXEL_BITS_DEF
);
   import ups_pkg::*;

   logic                           valid;
   logic                           ready;
   logic signed [PIXEL_BITS+3:0]   value;
   logic        [PLANE_BITS-1:0]   plane;
   logic        [COORD_BITS-1:0]   out_row;
   logic        [COORD_BITS-1:0]   out_col;
   logic                           last;

   modport source (output valid, output value, output plane, output out_row,
                   output out_col, output last, input ready);
   modport sink (input valid, input value, input plane, input out_row,
                 input out_col, input last, output ready);
endinterface

// ----- rtl/core/ups_ram.sv -----
// Generic single-port RAM with registered, read-before-write output.
// Depends on nothing.
`timescale 1ns / 1ps

module ups_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     enable,
   input  logic                     write,
   input  logic [$clog2(DEPTH)-1:0] address,
   input  logic [WIDTH-1:0]         write_data,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (enable) begin
         read_data <= mem[address];
         if (write) begin
            mem[address] <= write_data;
         end
      end
   end

endmodule

// ----- rtl/core/ups_emit.sv -----
// Result sequencer of the 2x upsampler: walks the outputs of one pixel and
// holds the response register. Depends on ups_pkg, ups_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ups_emit #(
   parameter int PIXEL_BITS = ups_pkg::PIXEL_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  ups_pkg::ups_item_type        item,
   input  logic signed [PIXEL_BITS-1:0] pixel,
   input  logic signed [PIXEL_BITS-1:0] left,
   input  logic signed [PIXEL_BITS-1:0] above,
   input  logic signed [PIXEL_BITS-1:0] above_left,
   output logic                         take,
   ups_rsp_if.source                    rsp
);
   import ups_pkg::*;

   localparam int QB = PIXEL_BITS + 2;
   localparam int VB = PIXEL_BITS + 4;

   logic                 s2_valid_ff, s2_valid_in;
   ups_item_type         item_ff;
   row_kind_type         row_ff, row_in, row_nxt;
   col_kind_type         col_ff, col_in, col_nxt;
   logic signed [QB-1:0] e_l_ff, e_c_ff, u_l_ff, u_c_ff, d_l_ff, d_c_ff;
   logic signed [QB-1:0] xq, lq, aq, alq;
   logic signed [QB-1:0] sel_l, sel_c;
   logic signed [VB-1:0] vl, vc, value_in;
   logic [COORD_BITS-1:0] row_out_in, col_out_in;
   logic                 col_end, row_done, is_last, emit;

   logic                  rsp_valid_ff;
   logic signed [VB-1:0]  value_ff;
   logic [PLANE_BITS-1:0] plane_ff;
   logic [COORD_BITS-1:0] row_out_ff, col_out_ff;
   logic                  last_ff;

   function automatic col_kind_type col_start(input ups_item_type it);
      col_kind_type k;
      if (it.near) begin
         k = COL_NEAR_EVEN;
      end else if (it.first_col) begin
         k = COL_FIRST;
      end else begin
         k = COL_ODD;
      end
      return k;
   endfunction

   function automatic row_kind_type row_start(input ups_item_type it);
      row_kind_type k;
      if (it.near) begin
         k = ROW_NEAR_EVEN;
      end else if (it.first_row) begin
         k = ROW_TOP;
      end else begin
         k = ROW_UP;
      end
      return k;
   endfunction

   assign xq  = QB'(pixel);
   assign lq  = QB'(left);
   assign aq  = QB'(above);
   assign alq = QB'(above_left);

   always_comb begin
      col_end = 1'b0;
      col_nxt = col_ff;
      case (col_ff)
         COL_FIRST: begin
            col_end = !item_ff.last_col;
            col_nxt = COL_EDGE;
         end
         COL_ODD: begin
            col_nxt = COL_EVEN;
         end
         COL_EVEN: begin
            col_end = !item_ff.last_col;
            col_nxt = COL_EDGE;
         end
         COL_NEAR_EVEN: begin
            col_nxt = COL_NEAR_ODD;
         end
         default: begin
            col_end = 1'b1;
         end
      endcase

      row_done = 1'b0;
      row_nxt  = row_ff;
      case (row_ff)
         ROW_TOP: begin
            row_done = !item_ff.last_row;
            row_nxt  = ROW_BOTTOM;
         end
         ROW_UP: begin
            row_nxt = ROW_DOWN;
         end
         ROW_DOWN: begin
            row_done = !item_ff.last_row;
            row_nxt  = ROW_BOTTOM;
         end
         ROW_NEAR_EVEN: begin
            row_nxt = ROW_NEAR_ODD;
         end
         default: begin
            row_done = 1'b1;
         end
      endcase

      is_last = col_end && row_done;
      emit    = s2_valid_ff && (!rsp_valid_ff || rsp.ready);
      take    = !s2_valid_ff || (emit && is_last);

      s2_valid_in = s2_valid_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      if (load) begin
         s2_valid_in = 1'b1;
         row_in      = row_start(item);
         col_in      = col_start(item);
      end else if (emit && is_last) begin
         s2_valid_in = 1'b0;
      end else if (emit) begin
         if (col_end) begin
            row_in = row_nxt;
            col_in = col_start(item_ff);
         end else begin
            col_in = col_nxt;
         end
      end
   end

   always_comb begin
      case (row_ff)
         ROW_UP: begin
            sel_l = u_l_ff;
            sel_c = u_c_ff;
         end
         ROW_DOWN: begin
            sel_l = d_l_ff;
            sel_c = d_c_ff;
         end
         default: begin
            sel_l = e_l_ff;
            sel_c = e_c_ff;
         end
      endcase
      vl = VB'(sel_l);
      vc = VB'(sel_c);

      case (col_ff)
         COL_ODD:  value_in = (vl <<< 1) + vl + vc;
         COL_EVEN: value_in = vl + (vc <<< 1) + vc;
         default:  value_in = vc <<< 2;
      endcase

      case (row_ff)
         ROW_TOP:      row_out_in = '0;
         ROW_UP:       row_out_in = item_ff.row2 - COORD_BITS'(1);
         ROW_BOTTOM:   row_out_in = item_ff.bottom_row;
         ROW_NEAR_ODD: row_out_in = item_ff.row2 + COORD_BITS'(1);
         default:      row_out_in = item_ff.row2;
      endcase

      case (col_ff)
         COL_FIRST:    col_out_in = '0;
         COL_ODD:      col_out_in = item_ff.col2 - COORD_BITS'(1);
         COL_EDGE:     col_out_in = item_ff.edge_col;
         COL_NEAR_ODD: col_out_in = item_ff.col2 + COORD_BITS'(1);
         default:      col_out_in = item_ff.col2;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         row_ff       <= ROW_TOP;
         col_ff       <= COL_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
         e_l_ff  <= lq <<< 2;
         e_c_ff  <= xq <<< 2;
         u_l_ff  <= (alq <<< 1) + alq + lq;
         u_c_ff  <= (aq <<< 1) + aq + xq;
         d_l_ff  <= alq + (lq <<< 1) + lq;
         d_c_ff  <= aq + (xq <<< 1) + xq;
      end
      if (emit) begin
         value_ff   <= value_in;
         plane_ff   <= item_ff.plane;
         row_out_ff <= row_out_in;
         col_out_ff <= col_out_in;
         last_ff    <= is_last;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.value   = value_ff;
   assign rsp.plane   = plane_ff;
   assign rsp.out_row = row_out_ff;
   assign rsp.out_col = col_out_ff;
   assign rsp.last    = last_ff;

   `ASSERT_IMPLIES(a_near_rows, clock, reset, s2_valid_ff && item_ff.near,
      row_ff == ROW_NEAR_EVEN || row_ff == ROW_NEAR_ODD, "bilinear row in nearest mode")
   `ASSERT_NEXT(a_keep_item, clock, reset, emit && !is_last, s2_valid_ff,
      "pixel dropped before its last result")

endmodule

// ----- rtl/core/upsample2x_bilinear_nearest_core.sv -----
// Top level of the 2x bilinear / nearest upsampler: registers, raster
// counters, line store and read stage. Depends on ups_pkg, ups_if, ups_ram,
// ups_emit and assert_macros.svh.
//
//   channel  direction  payload                                  handshake
//   req      in         pixel                                    valid / ready
//   rsp      out        value, plane, out_row, out_col, last     valid / ready
//   csr      in         csr_index, csr_data                      csr_write
//
// One result leaves per cycle while rsp.ready is high; a pixel yields 4 results
// for interior bilinear pixels and in nearest mode, and 1 to 9 at the edges.
// The result sequencer sets that number; the line store is read and written
// once per request, in the cycle it is accepted, so it never holds up a request.
// A request passes the read stage and the sequencer into the response register.
// Reset is synchronous and clears control state; the line store is not cleared.
// With rsp.ready low the response register holds and one request waits in the
// read stage and one in the sequencer before req.ready drops.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module upsample2x_bilinear_nearest_core #(
   parameter int MAX_WIDTH  = ups_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = ups_pkg::MAX_HEIGHT_DEF,
   parameter int PIXEL_BITS = ups_pkg::PIXEL_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [ups_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ups_pkg::CSR_DATA_BITS-1:0]  csr_data,
   ups_req_if.sink                            req,
   ups_rsp_if.source                          rsp
);
   import ups_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int WN = $clog2(MAX_WIDTH + 1);
   localparam int HN = $clog2(MAX_HEIGHT + 1);

   logic                  cfg_mode_ff;
   logic [GEOM_BITS-1:0]  cfg_width_ff, cfg_height_ff;
   logic [PLANE_BITS-1:0] cfg_planes_ff;
   logic                  restart;

   logic [WN-1:0]         w_eff;
   logic [HN-1:0]         h_eff;
   logic [PLANE_BITS-1:0] p_eff;

   logic [CW-1:0]         col_ff, col_in;
   logic [RW-1:0]         row_ff, row_in;
   logic [PLANE_BITS-1:0] plane_ff, plane_in;
   logic                  last_col, last_row, last_plane;

   logic signed [PIXEL_BITS-1:0] left_ff, above_left_ff, above_pix;
   logic                         s1_valid_ff;
   logic signed [PIXEL_BITS-1:0] s1_pixel_ff, s1_left_ff;
   ups_item_type                 s1_item_ff, item_in;
   logic                         accept, s1_move, take;

   always_comb begin
      case (csr_index)
         CSR_MODE, CSR_IN_WIDTH, CSR_IN_HEIGHT, CSR_PLANE_COUNT: restart = csr_write;
         default: restart = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_mode_ff   <= MODE_BILINEAR;
         cfg_width_ff  <= GEOM_BITS'(1);
         cfg_height_ff <= GEOM_BITS'(1);
         cfg_planes_ff <= PLANE_BITS'(1);
      end else if (csr_write) begin
         case (csr_index)
            CSR_MODE:        cfg_mode_ff   <= csr_data[0];
            CSR_IN_WIDTH:    cfg_width_ff  <= csr_data[GEOM_BITS-1:0];
            CSR_IN_HEIGHT:   cfg_height_ff <= csr_data[GEOM_BITS-1:0];
            CSR_PLANE_COUNT: cfg_planes_ff <= csr_data[PLANE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (cfg_width_ff == '0) begin
         w_eff = WN'(1);
      end else if (32'(cfg_width_ff) > MAX_WIDTH) begin
         w_eff = WN'(MAX_WIDTH);
      end else begin
         w_eff = WN'(cfg_width_ff);
      end
      if (cfg_height_ff == '0) begin
         h_eff = HN'(1);
      end else if (32'(cfg_height_ff) > MAX_HEIGHT) begin
         h_eff = HN'(MAX_HEIGHT);
      end else begin
         h_eff = HN'(cfg_height_ff);
      end
      p_eff = (cfg_planes_ff == '0) ? PLANE_BITS'(1) : cfg_planes_ff;
   end

   assign last_col   = (WN'(col_ff) + WN'(1)) == w_eff;
   assign last_row   = (HN'(row_ff) + HN'(1)) == h_eff;
   assign last_plane = ({1'b0, plane_ff} + 17'd1) >= {1'b0, p_eff};

   always_comb begin
      col_in   = col_ff + CW'(1);
      row_in   = row_ff;
      plane_in = plane_ff;
      if (last_col) begin
         col_in = '0;
         if (last_row) begin
            row_in   = '0;
            plane_in = last_plane ? '0 : plane_ff + PLANE_BITS'(1);
         end else begin
            row_in = row_ff + RW'(1);
         end
      end

      item_in.near       = cfg_mode_ff == MODE_NEAREST;
      item_in.first_col  = col_ff == '0;
      item_in.last_col   = last_col;
      item_in.first_row  = row_ff == '0;
      item_in.last_row   = last_row;
      item_in.row2       = COORD_BITS'(32'(row_ff) << 1);
      item_in.col2       = COORD_BITS'(32'(col_ff) << 1);
      item_in.bottom_row = COORD_BITS'((32'(h_eff) << 1) - 32'd1);
      item_in.edge_col   = COORD_BITS'((32'(w_eff) << 1) - 32'd1);
      item_in.plane      = plane_ff;
   end

   assign s1_move   = s1_valid_ff && take;
   assign req.ready = !s1_valid_ff || s1_move;
   assign accept    = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         plane_ff      <= '0;
         left_ff       <= '0;
         above_left_ff <= '0;
         s1_valid_ff   <= 1'b0;
      end else if (restart) begin
         col_ff        <= '0;
         row_ff        <= '0;
         plane_ff      <= '0;
         left_ff       <= '0;
         above_left_ff <= '0;
      end else begin
         if (accept) begin
            col_ff   <= col_in;
            row_ff   <= row_in;
            plane_ff <= plane_in;
            left_ff  <= req.pixel;
         end
         if (s1_move) begin
            above_left_ff <= above_pix;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req.pixel;
         s1_left_ff  <= left_ff;
         s1_item_ff  <= item_in;
      end
   end

   ups_ram #(
      .WIDTH(PIXEL_BITS),
      .DEPTH(MAX_WIDTH)
   ) u_line_store (
      .clock     (clock),
      .enable    (accept),
      .write     (accept),
      .address   (col_ff),
      .write_data(req.pixel),
      .read_data (above_pix)
   );

   ups_emit #(
      .PIXEL_BITS(PIXEL_BITS)
   ) u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (s1_move),
      .item      (s1_item_ff),
      .pixel     (s1_pixel_ff),
      .left      (s1_left_ff),
      .above     (above_pix),
      .above_left(above_left_ff),
      .take      (take),
      .rsp       (rsp)
   );

   `ASSERT_IMPLIES(a_col_in_range, clock, reset, 1'b1, WN'(col_ff) < w_eff,
      "column counter beyond row width")
   `ASSERT_NEXT(a_stage_held, clock, reset, s1_valid_ff && !s1_move,
      s1_valid_ff && $stable(s1_pixel_ff), "read stage lost a waiting request")

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench of the 2x bilinear / nearest upsampler core.
// Drives pixel requests and register writes, predicts every output pixel and
// checks it field by field. Depends on ups_pkg, ups_if and the core RTL.
`timescale 1ns / 1ps

module testbench;
   import ups_pkg::*;

   localparam int PIXEL_BITS = PIXEL_BITS_DEF;
   localparam int VALUE_BITS = PIXEL_BITS + 4;
   localparam int STALL_PCT  = 17;
   localparam int RANDOM_PIXELS = 300;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic [PLANE_BITS-1:0]        plane;
      logic [COORD_BITS-1:0]        row;
      logic [COORD_BITS-1:0]        col;
      logic                         last;
   } upsampled_pixel_type;

   logic clock;
   logic reset;
   logic csr_write;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;

   ups_req_if #(.PIXEL_BITS(PIXEL_BITS)) req_ch ();
   ups_rsp_if #(.PIXEL_BITS(PIXEL_BITS)) rsp_ch ();

   upsample2x_bilinear_nearest_core DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req       (req_ch),
      .rsp       (rsp_ch)
   );

   // Register copy and raster state of the predictor.
   logic                  cfg_mode;
   logic [GEOM_BITS-1:0]  cfg_width;
   logic [GEOM_BITS-1:0]  cfg_height;
   logic [PLANE_BITS-1:0] cfg_planes;

   logic signed [PIXEL_BITS-1:0] row_store [MAX_WIDTH_DEF];
   logic signed [PIXEL_BITS-1:0] left_px;
   logic signed [PIXEL_BITS-1:0] above_left_px;
   int col_idx;
   int row_idx;
   int plane_idx;

   logic signed [PIXEL_BITS-1:0] pixels_to_send [$];
   upsampled_pixel_type          step_outputs [$];
   upsampled_pixel_type          pending_outputs [$];

   bit no_stalls;
   int failures;
   int pixels_accepted;
   int outputs_checked;
   int configurations;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic restart_raster();
      left_px = '0;
      above_left_px = '0;
      col_idx = 0;
      row_idx = 0;
      plane_idx = 0;
   endtask

   task automatic emit_output(int row, int col, int value);
      upsampled_pixel_type o;
      o.value = VALUE_BITS'(value);
      o.plane = PLANE_BITS'(plane_idx);
      o.row = COORD_BITS'(row);
      o.col = COORD_BITS'(col);
      o.last = 1'b0;
      step_outputs.push_back(o);
   endtask

   // The vertical blend vl and vc are in quarters; horizontal weights add the rest.
   task automatic emit_row(int row, int c, int w, int vl, int vc);
      if (c == 0) begin
         emit_output(row, 0, 4 * vc);
      end else begin
         emit_output(row, 2 * c - 1, 3 * vl + vc);
         emit_output(row, 2 * c, vl + 3 * vc);
      end
      if (c == w - 1) begin
         emit_output(row, 2 * w - 1, 4 * vc);
      end
   endtask

   task automatic predict_upsampled(logic signed [PIXEL_BITS-1:0] px);
      int w, h, p, r, c, x, a, l, al;
      upsampled_pixel_type tail;
      w = (cfg_width == 0) ? 1 :
          ((cfg_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(cfg_width));
      h = (cfg_height == 0) ? 1 :
          ((cfg_height > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(cfg_height));
      p = (cfg_planes == 0) ? 1 : int'(cfg_planes);
      if (col_idx >= w) col_idx = 0;
      if (row_idx >= h) row_idx = 0;
      if (plane_idx >= p) plane_idx = 0;
      r = row_idx;
      c = col_idx;
      x = int'(px);
      a = int'(row_store[c]);
      l = int'(left_px);
      al = int'(above_left_px);
      step_outputs.delete();
      if (cfg_mode == MODE_NEAREST) begin
         emit_output(2 * r, 2 * c, 16 * x);
         emit_output(2 * r, 2 * c + 1, 16 * x);
         emit_output(2 * r + 1, 2 * c, 16 * x);
         emit_output(2 * r + 1, 2 * c + 1, 16 * x);
      end else begin
         if (r == 0) emit_row(0, c, w, 4 * l, 4 * x);
         if (r >= 1) begin
            emit_row(2 * r - 1, c, w, 3 * al + l, 3 * a + x);
            emit_row(2 * r, c, w, al + 3 * l, a + 3 * x);
         end
         if (r == h - 1) emit_row(2 * h - 1, c, w, 4 * l, 4 * x);
      end
      tail = step_outputs.pop_back();
      tail.last = 1'b1;
      step_outputs.push_back(tail);
      while (step_outputs.size() != 0) pending_outputs.push_back(step_outputs.pop_front());
      row_store[c] = px;
      above_left_px = PIXEL_BITS'(a);
      left_px = px;
      col_idx = c + 1;
      if (col_idx >= w) begin
         col_idx = 0;
         row_idx = r + 1;
         if (row_idx >= h) begin
            row_idx = 0;
            plane_idx = plane_idx + 1;
            if (plane_idx >= p) plane_idx = 0;
         end
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pixels_to_send.size() != 0 || req_ch.valid || pending_outputs.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_register(logic [CSR_INDEX_BITS-1:0] index,
                                 logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      case (index)
         CSR_MODE:        cfg_mode = data[0];
         CSR_IN_WIDTH:    cfg_width = data[GEOM_BITS-1:0];
         CSR_IN_HEIGHT:   cfg_height = data[GEOM_BITS-1:0];
         CSR_PLANE_COUNT: cfg_planes = data;
         default: ;
      endcase
      restart_raster();
   endtask

   task automatic program_geometry(logic mode, logic [CSR_DATA_BITS-1:0] w,
                                   logic [CSR_DATA_BITS-1:0] h,
                                   logic [CSR_DATA_BITS-1:0] p);
      wait_drained();
      write_register(CSR_MODE, {{(CSR_DATA_BITS-1){1'b0}}, mode});
      write_register(CSR_IN_WIDTH, w);
      write_register(CSR_IN_HEIGHT, h);
      write_register(CSR_PLANE_COUNT, p);
      @(posedge clock);
      csr_write <= 1'b0;
      configurations++;
      @(negedge clock);
   endtask

   function automatic logic signed [PIXEL_BITS-1:0] random_pixel();
      case ($urandom_range(7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return '0;
         default: return PIXEL_BITS'($urandom);
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_upsampled(req_ch.pixel);
            pixels_accepted++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pixels_to_send.size() != 0 &&
                (no_stalls || $urandom_range(99) >= STALL_PCT)) begin
               req_ch.valid <= 1'b1;
               req_ch.pixel <= pixels_to_send.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : output_check
      upsampled_pixel_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_outputs.size() == 0) begin
               $error("unexpected output pixel: value %0d plane %0d row %0d col %0d",
                      rsp_ch.value, rsp_ch.plane, rsp_ch.out_row, rsp_ch.out_col);
               failures++;
            end else begin
               want = pending_outputs.pop_front();
               outputs_checked++;
               if (rsp_ch.value !== want.value) begin
                  $error("value: expected %0d, got %0d", want.value, rsp_ch.value);
                  failures++;
               end
               if (rsp_ch.plane !== want.plane) begin
                  $error("plane: expected %0d, got %0d", want.plane, rsp_ch.plane);
                  failures++;
               end
               if (rsp_ch.out_row !== want.row) begin
                  $error("out_row: expected %0d, got %0d", want.row, rsp_ch.out_row);
                  failures++;
               end
               if (rsp_ch.out_col !== want.col) begin
                  $error("out_col: expected %0d, got %0d", want.col, rsp_ch.out_col);
                  failures++;
               end
               if (rsp_ch.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_ch.last);
                  failures++;
               end
            end
         end
         rsp_ch.ready <= no_stalls || ($urandom_range(99) >= STALL_PCT);
      end
   end

   initial begin
      int w, h, p, planes_sent, total, round, random_pixels;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.pixel = '0;
      rsp_ch.ready = 1'b0;
      no_stalls = 1'b0;
      failures = 0;
      pixels_accepted = 0;
      outputs_checked = 0;
      configurations = 1;
      cfg_mode = MODE_BILINEAR;
      cfg_width = GEOM_BITS'(1);
      cfg_height = GEOM_BITS'(1);
      cfg_planes = PLANE_BITS'(1);
      foreach (row_store[i]) row_store[i] = '0;
      restart_raster();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // A one by one image at reset values wraps the plane on every pixel.
      pixels_to_send.push_back(16'sh7FFF);
      pixels_to_send.push_back(16'sh8000);

      program_geometry(MODE_NEAREST, CSR_DATA_BITS'(2), CSR_DATA_BITS'(2),
                       CSR_DATA_BITS'(2));
      pixels_to_send.push_back(16'sh7FFF);
      pixels_to_send.push_back(16'sh8000);
      pixels_to_send.push_back(16'sh0000);
      pixels_to_send.push_back(16'shFFFF);
      pixels_to_send.push_back(16'sh3039);

      // Zero geometry acts as one row, one column and one plane.
      program_geometry(MODE_BILINEAR, '0, '0, '0);
      pixels_to_send.push_back(16'shFFFF);
      pixels_to_send.push_back(16'sh0001);

      // Oversized geometry clamps to the maximum; the run is cut short by the next write.
      program_geometry(MODE_BILINEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      pixels_to_send.push_back(16'sh5555);
      pixels_to_send.push_back(16'shAAAA);
      pixels_to_send.push_back(16'sh0000);

      // Upper data bits are dropped, so this is a three by two plane of extremes.
      program_geometry(MODE_BILINEAR, 16'hF003, CSR_DATA_BITS'(2), CSR_DATA_BITS'(1));
      pixels_to_send.push_back(16'sh7FFF);
      pixels_to_send.push_back(16'sh8000);
      pixels_to_send.push_back(16'sh7FFF);
      pixels_to_send.push_back(16'sh8000);
      pixels_to_send.push_back(16'sh7FFF);
      pixels_to_send.push_back(16'sh8000);

      random_pixels = 0;
      round = 0;
      while (random_pixels < RANDOM_PIXELS) begin
         w = $urandom_range(1, 12);
         h = $urandom_range(1, 6);
         p = $urandom_range(1, 3);
         // The first random round is a full-size image sent with no idle cycles.
         if (round == 0) begin
            w = 12;
            h = 6;
         end
         planes_sent = $urandom_range(1, p + 1);
         total = planes_sent * w * h + $urandom_range(0, w * h - 1);
         if (total > RANDOM_PIXELS - random_pixels) begin
            total = RANDOM_PIXELS - random_pixels;
         end
         program_geometry(($urandom_range(3) == 0) ? MODE_NEAREST : MODE_BILINEAR,
                          CSR_DATA_BITS'(w), CSR_DATA_BITS'(h), CSR_DATA_BITS'(p));
         no_stalls = (round == 0);
         repeat (total) pixels_to_send.push_back(random_pixel());
         random_pixels += total;
         round++;
      end

      wait_drained();
      no_stalls = 1'b0;
      repeat (16) @(posedge clock);
      $display("Checked %0d output pixels from %0d input pixels over %0d register settings,",
               outputs_checked, pixels_accepted, configurations);
      $display("in both modes, with clamped geometry, partial planes and plane wrap.");
      if (failures == 0 && pending_outputs.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/ups_pkg.sv
rtl/core/ups_if.sv
rtl/core/ups_ram.sv
rtl/core/ups_emit.sv
rtl/core/upsample2x_bilinear_nearest_core.sv
tb/sv/testbench.sv
